FILE: rtl/orch_pkg.sv
// ----------------------------------------------------------------------------
// orch_pkg
// Shared constants and types of the optimal replacement cache heap.
// ----------------------------------------------------------------------------
package orch_pkg;

    localparam int CAPACITY    = 16;
    localparam int NUM_OBJECTS = 256;
    localparam int TIME_WIDTH  = 16;

    localparam int ID_W    = 8;
    localparam int KEY_W   = TIME_WIDTH;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W  = $clog2(CAPACITY + 1);
    localparam int OBJ_W   = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  obj;
    } t_slot;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [ID_W-1:0]    evicted_id;
        logic [COUNT_W-1:0] miss_count;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [OBJ_W-1:0]  addr;
        logic [FILL_W-1:0] data;
    } t_pmap_wr;

endpackage

FILE: rtl/orch_req_if.sv
// ----------------------------------------------------------------------------
// orch_req_if
// Request channel: object id, next-use time and no-more-uses flag.
// ----------------------------------------------------------------------------
interface orch_req_if import orch_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  obj_id;
    logic [KEY_W-1:0] next_use;
    logic             no_more_uses;

    modport source (output valid, output obj_id, output next_use, output no_more_uses,
                    input ready);
    modport sink   (input valid, input obj_id, input next_use, input no_more_uses,
                    output ready);

endinterface

FILE: rtl/orch_rsp_if.sv
// ----------------------------------------------------------------------------
// orch_rsp_if
// Result channel: hit, eviction and running miss count.
// ----------------------------------------------------------------------------
interface orch_rsp_if import orch_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               hit;
    logic               evicted_valid;
    logic [ID_W-1:0]    evicted_id;
    logic [COUNT_W-1:0] miss_count;

    modport source (output valid, output hit, output evicted_valid, output evicted_id,
                    output miss_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_id,
                    input miss_count, output ready);

endinterface

FILE: rtl/optimal_replacement_cache_heap.sv
// ----------------------------------------------------------------------------
// optimal_replacement_cache_heap
// Farthest-next-use cache simulator built on an indexed max-heap.
// ----------------------------------------------------------------------------
// Each request on i_req carries an object id and its next-use time, or the
// no-more-uses flag, which takes the key from the never_key register written
// over i_cfg_we / i_cfg_wdata. Each request yields exactly one result on
// o_rsp: hit, eviction flag and id, and the saturating miss count.
// Requests are handled one at a time by a sequencer around a heap slot
// memory and a position map, each with one read and one write port, and one
// shared key comparator; a sift-up level passes through S_UP and S_UP_CMP, a
// sift-down level through S_DN, S_DN_L, S_DN_RC when a right child exists,
// and S_DN_CMP. After a result is taken the sequencer returns to idle before
// the next request is accepted.
// i_req.ready is high only while the sequencer is idle. A finished result
// moves into the output register, so the next request is taken while that
// result waits; a stalled receiver holds the result and blocks only the
// following one. Synchronous reset empties the cache, marks every object
// absent, clears the miss count and sets never_key to all ones.
// ----------------------------------------------------------------------------
module optimal_replacement_cache_heap import orch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    orch_req_if.sink         i_req,
    orch_rsp_if.source       o_rsp
);

    logic [KEY_W-1:0]  r_never_key, n_never_key;
    logic              r_out_vld,   n_out_vld;
    t_result           r_out,       n_out;

    t_item             item;
    logic              idle;
    logic              done;
    logic              take;
    logic              accept;
    t_result           result;
    logic [OBJ_W-1:0]  pmap_raddr;
    logic [FILL_W-1:0] pmap_rdata;
    t_pmap_wr          pmap_wr;

    assign item.id  = i_req.obj_id;
    assign item.key = i_req.no_more_uses ? r_never_key : KEY_W'(i_req.next_use);

    assign i_req.ready = idle;
    assign accept      = i_req.valid && idle;
    assign take        = done && (!r_out_vld || o_rsp.ready);

    orch_heap_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_item       (item),
        .o_idle       (idle),
        .o_done       (done),
        .o_result     (result),
        .i_take       (take),
        .o_pmap_raddr (pmap_raddr),
        .i_pmap_rdata (pmap_rdata),
        .o_pmap_wr    (pmap_wr)
    );

    orch_pos_map u_pos_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (pmap_raddr),
        .o_rdata (pmap_rdata),
        .i_wr    (pmap_wr)
    );

    always_comb begin
        n_never_key = r_never_key;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        if (i_cfg_we) begin
            n_never_key = KEY_W'(i_cfg_wdata);
        end
        if (take) begin
            n_out     = result;
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_never_key <= '1;
            r_out_vld   <= 1'b0;
        end else begin
            r_never_key <= n_never_key;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.evicted_valid = r_out.evicted_valid;
    assign o_rsp.evicted_id    = r_out.evicted_id;
    assign o_rsp.miss_count    = r_out.miss_count;

endmodule

FILE: rtl/orch_pos_map.sv
// ----------------------------------------------------------------------------
// orch_pos_map
// Object to heap slot map: one write and one registered read per cycle,
// per-entry valid bits so that unwritten entries read as absent.
// ----------------------------------------------------------------------------
module orch_pos_map import orch_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [OBJ_W-1:0]  i_raddr,
    output logic [FILL_W-1:0] o_rdata,
    input  t_pmap_wr          i_wr
);

    logic [FILL_W-1:0]      r_mem [NUM_OBJECTS];
    logic [NUM_OBJECTS-1:0] r_vld;
    logic [FILL_W-1:0]      r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : FILL_W'(CAPACITY);

endmodule

FILE: rtl/orch_heap_ctrl.sv
// ----------------------------------------------------------------------------
// orch_heap_ctrl
// Heap slot memory, shared key comparator and the sequencer that walks
// lookup, eviction, sift-down, insertion and sift-up one step per cycle.
// ----------------------------------------------------------------------------
module orch_heap_ctrl import orch_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_item             i_item,
    output logic              o_idle,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_take,
    output logic [OBJ_W-1:0]  o_pmap_raddr,
    input  logic [FILL_W-1:0] i_pmap_rdata,
    output t_pmap_wr          o_pmap_wr
);

    localparam int DN_W = SLOT_W + 2;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_CHECK  = 12'b0000_0000_0010,
        S_EV0    = 12'b0000_0000_0100,
        S_EV1    = 12'b0000_0000_1000,
        S_DN     = 12'b0000_0001_0000,
        S_DN_L   = 12'b0000_0010_0000,
        S_DN_RC  = 12'b0000_0100_0000,
        S_DN_CMP = 12'b0000_1000_0000,
        S_INS    = 12'b0001_0000_0000,
        S_UP     = 12'b0010_0000_0000,
        S_UP_CMP = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state              r_state,     n_state;
    logic [ID_W-1:0]     r_id,        n_id;
    logic [KEY_W-1:0]    r_key,       n_key;
    t_slot               r_cur,       n_cur;
    t_slot               r_big,       n_big;
    logic [SLOT_W-1:0]   r_pos,       n_pos;
    logic [SLOT_W-1:0]   r_big_pos,   n_big_pos;
    logic [FILL_W-1:0]   r_filled,    n_filled;
    logic [COUNT_W-1:0]  r_count,     n_count;
    logic                r_hit,       n_hit;
    logic                r_ev_valid,  n_ev_valid;
    logic [ID_W-1:0]     r_ev_id,     n_ev_id;

    t_slot               r_heap [CAPACITY];
    t_slot               r_rd;
    logic                hw_en;
    logic [SLOT_W-1:0]   hw_addr;
    t_slot               hw_data;
    logic [SLOT_W-1:0]   hr_addr;

    logic [KEY_W-1:0]    cmp_a;
    logic [KEY_W-1:0]    cmp_b;
    logic                cmp_lt;

    logic [DN_W-1:0]     left;
    logic [DN_W-1:0]     right;
    logic [SLOT_W-1:0]   parent;

    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            r_heap[hw_addr] <= hw_data;
        end
        r_rd <= r_heap[hr_addr];
    end

    assign left   = (DN_W'(r_pos) << 1) + DN_W'(1);
    assign right  = left + DN_W'(1);
    assign parent = SLOT_W'((r_pos - SLOT_W'(1)) >> 1);

    always_comb begin
        unique case (r_state)
            S_UP_CMP: begin
                cmp_a = r_rd.key;
                cmp_b = r_cur.key;
            end
            S_DN_RC: begin
                cmp_a = r_big.key;
                cmp_b = r_rd.key;
            end
            default: begin
                cmp_a = r_cur.key;
                cmp_b = r_big.key;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        n_state    = r_state;
        n_id       = r_id;
        n_key      = r_key;
        n_cur      = r_cur;
        n_big      = r_big;
        n_pos      = r_pos;
        n_big_pos  = r_big_pos;
        n_filled   = r_filled;
        n_count    = r_count;
        n_hit      = r_hit;
        n_ev_valid = r_ev_valid;
        n_ev_id    = r_ev_id;
        hw_en      = 1'b0;
        hw_addr    = r_pos;
        hw_data    = r_cur;
        hr_addr    = '0;
        o_pmap_wr  = '{en: 1'b0, addr: OBJ_W'(r_cur.obj), data: FILL_W'(r_pos)};

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_id       = i_item.id;
                    n_key      = i_item.key;
                    n_hit      = 1'b0;
                    n_ev_valid = 1'b0;
                    n_ev_id    = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_pmap_rdata < r_filled) begin
                    n_hit   = 1'b1;
                    n_cur   = '{key: r_key, obj: r_id};
                    n_pos   = SLOT_W'(i_pmap_rdata);
                    n_state = S_UP;
                end else if (r_filled == FILL_W'(CAPACITY)) begin
                    hr_addr = '0;
                    n_state = S_EV0;
                end else begin
                    n_state = S_INS;
                end
            end
            S_EV0: begin
                n_ev_valid = 1'b1;
                n_ev_id    = r_rd.obj;
                n_filled   = FILL_W'(CAPACITY - 1);
                o_pmap_wr  = '{en: 1'b1, addr: OBJ_W'(r_rd.obj), data: FILL_W'(CAPACITY)};
                if (CAPACITY > 1) begin
                    hr_addr = SLOT_W'(CAPACITY - 1);
                    n_state = S_EV1;
                end else begin
                    n_state = S_INS;
                end
            end
            S_EV1: begin
                n_cur   = r_rd;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (left >= DN_W'(r_filled)) begin
                    hw_en        = 1'b1;
                    o_pmap_wr.en = 1'b1;
                    n_state      = S_INS;
                end else begin
                    hr_addr = SLOT_W'(left);
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                n_big     = r_rd;
                n_big_pos = SLOT_W'(left);
                if (right < DN_W'(r_filled)) begin
                    hr_addr = SLOT_W'(right);
                    n_state = S_DN_RC;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_RC: begin
                if (cmp_lt) begin
                    n_big     = r_rd;
                    n_big_pos = SLOT_W'(right);
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                hw_en = 1'b1;
                if (cmp_lt) begin
                    hw_data   = r_big;
                    o_pmap_wr = '{en: 1'b1, addr: OBJ_W'(r_big.obj), data: FILL_W'(r_pos)};
                    n_pos     = r_big_pos;
                    n_state   = S_DN;
                end else begin
                    o_pmap_wr.en = 1'b1;
                    n_state      = S_INS;
                end
            end
            S_INS: begin
                n_cur    = '{key: r_key, obj: r_id};
                n_pos    = SLOT_W'(r_filled);
                n_filled = r_filled + FILL_W'(1);
                if (r_count != '1) begin
                    n_count = r_count + COUNT_W'(1);
                end
                n_state  = S_UP;
            end
            S_UP: begin
                if (r_pos == '0) begin
                    hw_en        = 1'b1;
                    o_pmap_wr.en = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    hr_addr = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                hw_en = 1'b1;
                if (cmp_lt) begin
                    hw_data   = r_rd;
                    o_pmap_wr = '{en: 1'b1, addr: OBJ_W'(r_rd.obj), data: FILL_W'(r_pos)};
                    n_pos     = parent;
                    n_state   = S_UP;
                end else begin
                    o_pmap_wr.en = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_filled   <= '0;
            r_count    <= '0;
            r_hit      <= 1'b0;
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
        end else begin
            r_state    <= n_state;
            r_filled   <= n_filled;
            r_count    <= n_count;
            r_hit      <= n_hit;
            r_ev_valid <= n_ev_valid;
            r_ev_id    <= n_ev_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_key     <= n_key;
        r_cur     <= n_cur;
        r_big     <= n_big;
        r_pos     <= n_pos;
        r_big_pos <= n_big_pos;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_pmap_raddr = OBJ_W'(i_item.id);
    assign o_result     = '{hit: r_hit, evicted_valid: r_ev_valid, evicted_id: r_ev_id,
                            miss_count: r_count};

    a_start_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle && i_start) |=> (r_state == S_CHECK))
        else $error("accepted request did not enter lookup");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(r_hit && r_ev_valid))
        else $error("hit reported together with eviction");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_filled < FILL_W'(CAPACITY)))
        else $error("insertion into a full heap");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=>
            ((r_count == $past(r_count) + COUNT_W'(1)) || ($past(r_count) == '1)))
        else $error("miss count did not advance");

    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_hit) |-> $stable(r_count))
        else $error("miss count changed on a hit");

endmodule

FILE: sim/optimal_replacement_cache_heap_tb.sv
// ----------------------------------------------------------------------------
// optimal_replacement_cache_heap_tb
// Self-checking bench for the farthest-next-use cache heap.
// ----------------------------------------------------------------------------
// Drives access requests through the request channel and mirrors the cache in
// a behavioral max-heap with its own position map. Every result is checked
// field by field against the outcome predicted at request acceptance. Covers
// field extremes, hits that raise and lower keys, equal keys, evictions,
// several never_key settings, a long receiver hold-off, and random traffic
// with bursty senders and stalling receivers.
// ----------------------------------------------------------------------------
module optimal_replacement_cache_heap_tb;
    import orch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_style;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    orch_req_if req_if ();
    orch_rsp_if rsp_if ();

    optimal_replacement_cache_heap i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    // cache mirror
    logic [KEY_W-1:0]   heap_key [CAPACITY];
    logic [ID_W-1:0]    heap_obj [CAPACITY];
    int unsigned        obj_pos  [NUM_OBJECTS];
    int unsigned        heap_size;
    logic [COUNT_W-1:0] miss_total;
    logic [CFG_W-1:0]   far_key;

    t_result   pending_outcomes [$];
    t_result   want;
    int        fail_count;
    int        cycle_count;
    int        burst_left;
    bit        sender_bursty;
    t_rx_style rx_style;
    int        hold_left;
    int        long_hold_cycles;
    int        pat_step;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void exchange_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] k;
        logic [ID_W-1:0]  o;
        k           = heap_key[a];
        o           = heap_obj[a];
        heap_key[a] = heap_key[b];
        heap_obj[a] = heap_obj[b];
        heap_key[b] = k;
        heap_obj[b] = o;
        obj_pos[heap_obj[a]] = a;
        obj_pos[heap_obj[b]] = b;
    endfunction

    function automatic void raise_slot(int unsigned pos);
        int unsigned parent;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_key[pos] <= heap_key[parent]) break;
            exchange_slots(pos, parent);
            pos = parent;
        end
    endfunction

    function automatic void lower_slot(int unsigned pos);
        int unsigned left;
        int unsigned right;
        int unsigned big;
        while (1) begin
            left  = 2 * pos + 1;
            right = left + 1;
            if (left >= heap_size) break;
            big = left;
            if (right < heap_size && heap_key[left] < heap_key[right]) big = right;
            if (heap_key[big] <= heap_key[pos]) break;
            exchange_slots(pos, big);
            pos = big;
        end
    endfunction

    function automatic t_result predict_access(logic [ID_W-1:0] id, logic [KEY_W-1:0] nxt,
                                               logic nmu);
        t_result          r;
        logic [KEY_W-1:0] key;
        int unsigned      pos;
        r   = '0;
        key = nmu ? far_key[KEY_W-1:0] : nxt;
        pos = obj_pos[id];
        if (pos < heap_size) begin
            r.hit         = 1'b1;
            heap_key[pos] = key;
            raise_slot(pos);
        end else begin
            if (heap_size == CAPACITY) begin
                r.evicted_valid      = 1'b1;
                r.evicted_id         = heap_obj[0];
                obj_pos[heap_obj[0]] = CAPACITY;
                heap_size            = CAPACITY - 1;
                if (heap_size > 0) begin
                    heap_key[0]          = heap_key[heap_size];
                    heap_obj[0]          = heap_obj[heap_size];
                    obj_pos[heap_obj[0]] = 0;
                    lower_slot(0);
                end
            end
            pos           = heap_size;
            heap_key[pos] = key;
            heap_obj[pos] = id;
            obj_pos[id]   = pos;
            heap_size     = pos + 1;
            raise_slot(pos);
            if (miss_total != '1) miss_total = miss_total + 1'b1;
        end
        r.miss_count = miss_total;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     got_v);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual hit=%0d ev=%0d",
                         $time, rsp_if.hit, rsp_if.evicted_valid);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
                check_field("evicted_valid", 32'(want.evicted_valid),
                            32'(rsp_if.evicted_valid));
                check_field("evicted_id", 32'(want.evicted_id), 32'(rsp_if.evicted_id));
                check_field("miss_count", 32'(want.miss_count), 32'(rsp_if.miss_count));
            end
        end
    end

    // receiver: hold-offs take priority over the stall style
    always @(negedge clk) begin
        pat_step <= pat_step + 1;
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (long_hold_cycles > 0) begin
            rsp_if.ready     <= 1'b0;
            hold_left        <= long_hold_cycles - 1;
            long_hold_cycles = 0;
        end else begin
            case (rx_style)
                RX_STEADY: begin
                    rsp_if.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    if ($urandom_range(199) == 0) begin
                        rsp_if.ready <= 1'b0;
                        hold_left    <= $urandom_range(60, 20);
                    end else begin
                        rsp_if.ready <= ($urandom_range(9) >= 3);
                    end
                end
                default: begin
                    rsp_if.ready <= ((pat_step % 9) < 6);
                end
            endcase
        end
    end

    task automatic issue_access(input logic [ID_W-1:0] id, input logic [KEY_W-1:0] nxt,
                                input logic nmu);
        int gap;
        if (burst_left == 0) begin
            gap        = sender_bursty ? $urandom_range(6) : 0;
            burst_left = $urandom_range(24, 1);
            if (gap > 0) begin
                @(negedge clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_if.valid        <= 1'b1;
        req_if.obj_id       <= id;
        req_if.next_use     <= nxt;
        req_if.no_more_uses <= nmu;
        do @(posedge clk); while (!req_if.ready);
        pending_outcomes.push_back(predict_access(id, nxt, nmu));
    endtask

    task automatic random_access(int ws_base, int ws_size, int nmu_pct);
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] nxt;
        logic             nmu;
        if ($urandom_range(99) < 70)
            id = ID_W'(ws_base + $urandom_range(ws_size - 1));
        else
            id = ID_W'($urandom_range(NUM_OBJECTS - 1));
        if ($urandom_range(4) == 0)
            nxt = KEY_W'($urandom_range(7));
        else
            nxt = KEY_W'($urandom);
        nmu = ($urandom_range(99) < nmu_pct);
        issue_access(id, nxt, nmu);
    endtask

    task automatic drain_outcomes();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic load_far_key(input logic [CFG_W-1:0] value);
        drain_outcomes();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        far_key   = value;
    endtask

    task automatic test_directed_extremes();
        rx_style      = RX_STEADY;
        sender_bursty = 1'b0;
        issue_access(8'd0, 16'hFFFF, 1'b0);
        issue_access(8'd255, 16'h0000, 1'b0);
        issue_access(8'd7, 16'h5A5A, 1'b1);
        issue_access(8'd0, 16'd3, 1'b0);
        issue_access(8'd255, 16'hFFFE, 1'b0);
        issue_access(8'd7, 16'hA5A5, 1'b1);
        for (int i = 0; i < 13; i++) issue_access(ID_W'(100 + i), 16'd500, 1'b0);
        issue_access(8'd200, 16'd1, 1'b0);
        issue_access(8'd201, 16'd500, 1'b0);
        issue_access(8'd100, 16'd500, 1'b0);
        issue_access(8'd202, 16'h0000, 1'b1);
    endtask

    task automatic test_far_key_settings();
        logic [CFG_W-1:0] settings [4];
        settings = '{16'h0000, 16'h0001, CFG_W'($urandom), 16'hFFFF};
        rx_style      = RX_RANDOM;
        sender_bursty = 1'b1;
        foreach (settings[s]) begin
            load_far_key(settings[s]);
            repeat (10) random_access(40, 20, 50);
        end
    endtask

    task automatic test_back_pressure();
        rx_style      = RX_STEADY;
        sender_bursty = 1'b0;
        drain_outcomes();
        @(posedge clk);
        long_hold_cycles = 400;
        repeat (24) random_access(60, 24, 15);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: load_far_key(16'h8000);
                1: load_far_key(16'h0000);
                2: load_far_key(CFG_W'($urandom));
                default: load_far_key(16'hFFFF);
            endcase
            rx_style      = t_rx_style'(phase % 3);
            sender_bursty = (phase != 2);
            repeat (450) random_access($urandom_range(200), $urandom_range(40, 12), 12);
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_if.valid        = 1'b0;
        req_if.obj_id       = '0;
        req_if.next_use     = '0;
        req_if.no_more_uses = 1'b0;
        rsp_if.ready        = 1'b0;
        fail_count          = 0;
        cycle_count         = 0;
        burst_left          = 0;
        sender_bursty       = 1'b0;
        rx_style            = RX_STEADY;
        hold_left           = 0;
        long_hold_cycles    = 0;
        pat_step            = 0;
        foreach (obj_pos[i]) obj_pos[i] = CAPACITY;
        foreach (heap_key[i]) begin
            heap_key[i] = '0;
            heap_obj[i] = '0;
        end
        heap_size  = 0;
        miss_total = '0;
        far_key    = '1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_far_key_settings();
        test_back_pressure();
        test_random_traffic();

        drain_outcomes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/orch_pkg.sv
rtl/orch_req_if.sv
rtl/orch_rsp_if.sv
rtl/orch_pos_map.sv
rtl/orch_heap_ctrl.sv
rtl/optimal_replacement_cache_heap.sv
sim/optimal_replacement_cache_heap_tb.sv
